@@ rtl/core/adxf_pkg.sv @@
// Shared types, constants and the blend table of the dropout crossfader.
package adxf_pkg;

  localparam int TRANSITION_LEN = 64;
  localparam int SAMPLE_BITS    = 24;
  localparam int NCH            = 2;
  localparam int CH_W           = 1;
  localparam int CNT_W          = 2;
  localparam int HIST_W         = $clog2(TRANSITION_LEN);
  localparam int STEP_W         = $clog2(TRANSITION_LEN + 1);
  localparam int FRAC_W         = 16;
  localparam int BLEND_W        = FRAC_W + 1;
  localparam int PROD_W         = SAMPLE_BITS + BLEND_W + 1;
  localparam int ACC_W          = PROD_W + 1;
  localparam int OPC_W          = 3;
  localparam int CFG_IDX_W      = 1;

  typedef logic [OPC_W-1:0]              opcode_t;
  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [BLEND_W-1:0]            blend_t;
  typedef logic [CNT_W-1:0]              chan_cnt_t;
  typedef logic [CFG_IDX_W-1:0]          cfg_idx_t;

  localparam opcode_t OP_FRAME      = 3'd0;
  localparam opcode_t OP_MISSING    = 3'd1;
  localparam opcode_t OP_MUTE       = 3'd2;
  localparam opcode_t OP_RESTART    = 3'd3;
  localparam opcode_t OP_TRANSITION = 3'd4;

  localparam cfg_idx_t CFG_SOURCE_CH = 1'b0;
  localparam cfg_idx_t CFG_OUTPUT_CH = 1'b1;

  localparam chan_cnt_t CH_CNT_RESET = chan_cnt_t'(NCH);
  localparam blend_t    BLEND_ONE    = blend_t'(1 << FRAC_W);

  // Blend weight per step: round(2^16 * step / (LEN - 1)), halves up
  typedef blend_t blend_lut_t [TRANSITION_LEN];

  function automatic blend_lut_t build_blend_lut();
    blend_lut_t lut;
    for (int i = 0; i < TRANSITION_LEN; i++) begin
      lut[i] = blend_t'((i * (1 << FRAC_W) + (TRANSITION_LEN - 1) / 2) / (TRANSITION_LEN - 1));
    end
    return lut;
  endfunction

  localparam blend_lut_t BLEND_LUT = build_blend_lut();

  typedef enum logic [1:0] {
    A_ORIGIN,
    A_INPUT,
    A_HIST,
    A_TEMP
  } a_sel_t;

  typedef enum logic {
    B_GAIN,
    B_BLEND
  } b_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  typedef enum logic {
    RND_ACC,
    RND_PROD
  } rnd_src_t;

  typedef struct packed {
    logic            capture;
    logic            snap;
    logic            blend;
    logic            clear;
    logic            mul_en;
    a_sel_t          a_sel;
    b_sel_t          b_sel;
    acc_op_t         acc_op;
    rnd_src_t        rnd_src;
    logic            store_t;
    logic            store_frame;
    logic            commit;
    logic            emit;
    logic [CH_W-1:0] ch;
  } dp_cmd_t;

endpackage

@@ rtl/core/adxf_if.sv @@
// Stream interfaces for the input commands and the output frames.
interface adxf_in_if;
  logic               valid;
  logic               ready;
  adxf_pkg::opcode_t  opcode;
  adxf_pkg::sample_t  sample_left;
  adxf_pkg::sample_t  sample_right;

  modport source (output valid, opcode, sample_left, sample_right, input ready);
  modport sink   (input valid, opcode, sample_left, sample_right, output ready);
endinterface

interface adxf_out_if;
  logic               valid;
  logic               ready;
  adxf_pkg::sample_t  out_left;
  adxf_pkg::sample_t  out_right;

  modport source (output valid, out_left, out_right, input ready);
  modport sink   (input valid, out_left, out_right, output ready);
endinterface

@@ rtl/core/adxf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module adxf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/adxf_ctrl.sv @@
// Sequencer of the dropout crossfader: decodes commands and steps the datapath.
module adxf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  adxf_pkg::opcode_t   in_opcode,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output adxf_pkg::dp_cmd_t   cmd
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_PREP   = 10'b00_0000_0010,
    S_MUL_A  = 10'b00_0000_0100,
    S_MUL_B  = 10'b00_0000_1000,
    S_SUM    = 10'b00_0001_0000,
    S_RND    = 10'b00_0010_0000,
    S_MUL_T  = 10'b00_0100_0000,
    S_COMMIT = 10'b00_1000_0000,
    S_CLEAR  = 10'b01_0000_0000,
    S_EMIT   = 10'b10_0000_0000
  } state_t;

  localparam logic [adxf_pkg::CH_W-1:0] CH_LAST = adxf_pkg::CH_W'(adxf_pkg::NCH - 1);

  state_t                       state_r, state_nxt;
  adxf_pkg::opcode_t            op_r, op_nxt;
  logic [adxf_pkg::CH_W-1:0]    ch_r, ch_nxt;
  logic                         tpass_r, tpass_nxt;
  logic                         pending_r, pending_nxt;
  logic                         out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    ch_nxt        = ch_r;
    tpass_nxt     = tpass_r;
    pending_nxt   = pending_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.a_sel     = adxf_pkg::A_ORIGIN;
    cmd.b_sel     = adxf_pkg::B_GAIN;
    cmd.acc_op    = adxf_pkg::ACC_HOLD;
    cmd.rnd_src   = adxf_pkg::RND_ACC;
    cmd.ch        = ch_r;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          op_nxt      = in_opcode;
          unique case (in_opcode) inside
            adxf_pkg::OP_FRAME, adxf_pkg::OP_MISSING,
            adxf_pkg::OP_RESTART, adxf_pkg::OP_TRANSITION: state_nxt = S_PREP;
            adxf_pkg::OP_MUTE: state_nxt = S_CLEAR;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_PREP: begin
        ch_nxt    = '0;
        tpass_nxt = 1'b0;
        unique case (op_r)
          adxf_pkg::OP_FRAME: begin
            cmd.snap    = pending_r;
            cmd.blend   = 1'b1;
            pending_nxt = 1'b0;
            state_nxt   = S_MUL_A;
          end
          adxf_pkg::OP_MISSING: begin
            cmd.snap    = !pending_r;
            cmd.blend   = 1'b1;
            pending_nxt = 1'b1;
            state_nxt   = S_MUL_A;
          end
          adxf_pkg::OP_RESTART: begin
            cmd.snap    = 1'b1;
            pending_nxt = 1'b1;
            state_nxt   = S_IDLE;
          end
          default: begin
            cmd.snap  = 1'b1;
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_MUL_A: begin
        cmd.mul_en = 1'b1;
        cmd.a_sel  = adxf_pkg::A_ORIGIN;
        cmd.b_sel  = adxf_pkg::B_GAIN;
        state_nxt  = S_MUL_B;
      end
      S_MUL_B: begin
        cmd.mul_en = 1'b1;
        cmd.a_sel  = (op_r == adxf_pkg::OP_MISSING) ? adxf_pkg::A_HIST : adxf_pkg::A_INPUT;
        cmd.b_sel  = adxf_pkg::B_BLEND;
        cmd.acc_op = adxf_pkg::ACC_LOAD;
        state_nxt  = S_SUM;
      end
      S_SUM: begin
        cmd.acc_op = adxf_pkg::ACC_ADD;
        state_nxt  = S_RND;
      end
      S_RND: begin
        cmd.rnd_src = tpass_r ? adxf_pkg::RND_PROD : adxf_pkg::RND_ACC;
        if (op_r == adxf_pkg::OP_MISSING && !tpass_r) begin
          cmd.store_t = 1'b1;
          state_nxt   = S_MUL_T;
        end else begin
          cmd.store_frame = 1'b1;
          tpass_nxt       = 1'b0;
          if (ch_r == CH_LAST) begin
            state_nxt = S_COMMIT;
          end else begin
            ch_nxt    = ch_r + 1'b1;
            state_nxt = S_MUL_A;
          end
        end
      end
      S_MUL_T: begin
        cmd.mul_en = 1'b1;
        cmd.a_sel  = adxf_pkg::A_TEMP;
        cmd.b_sel  = adxf_pkg::B_GAIN;
        tpass_nxt  = 1'b1;
        state_nxt  = S_RND;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_EMIT;
      end
      S_CLEAR: begin
        cmd.clear   = 1'b1;
        pending_nxt = 1'b1;
        state_nxt   = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= adxf_pkg::OP_FRAME;
      ch_r        <= '0;
      tpass_r     <= 1'b0;
      pending_r   <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      ch_r        <= ch_nxt;
      tpass_r     <= tpass_nxt;
      pending_r   <= pending_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ rtl/core/adxf_datapath.sv @@
// Datapath of the dropout crossfader: history ring, blend state, shared MAC and rounding.
module adxf_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  adxf_pkg::cfg_idx_t  cfg_index,
  input  adxf_pkg::chan_cnt_t cfg_wdata,
  input  adxf_pkg::dp_cmd_t   cmd,
  input  adxf_pkg::sample_t   in_left,
  input  adxf_pkg::sample_t   in_right,
  output adxf_pkg::sample_t   out_left,
  output adxf_pkg::sample_t   out_right
);

  localparam int SB     = adxf_pkg::SAMPLE_BITS;
  localparam int ROW_W  = adxf_pkg::NCH * SB;
  localparam int HW     = adxf_pkg::HIST_W;
  localparam int SW     = adxf_pkg::STEP_W;
  localparam int AW     = adxf_pkg::ACC_W;
  localparam int PW     = adxf_pkg::PROD_W;

  localparam logic [HW-1:0] POS_MAX   = HW'(adxf_pkg::TRANSITION_LEN - 1);
  localparam logic [HW:0]   LEN_EXT   = (HW + 1)'(adxf_pkg::TRANSITION_LEN);
  localparam logic [SW-1:0] STEP_FULL = SW'(adxf_pkg::TRANSITION_LEN);
  localparam logic [SW-1:0] STEP_LAST = SW'(adxf_pkg::TRANSITION_LEN - 1);
  localparam logic signed [AW-1:0] RND_HALF = AW'(1 << (adxf_pkg::FRAC_W - 1));
  localparam logic signed [AW-1:0] SAT_MAX  = {{(AW - SB + 1){1'b0}}, {(SB - 1){1'b1}}};
  localparam logic signed [AW-1:0] SAT_MIN  = ~SAT_MAX;

  adxf_pkg::chan_cnt_t  src_cnt_r, out_cnt_r;
  adxf_pkg::sample_t    origin_r [adxf_pkg::NCH];
  adxf_pkg::sample_t    last_r   [adxf_pkg::NCH];
  adxf_pkg::sample_t    frame_r  [adxf_pkg::NCH];
  adxf_pkg::sample_t    smp_r    [adxf_pkg::NCH];
  adxf_pkg::sample_t    t_r, out_left_r, out_right_r;
  logic [HW-1:0]        hi_r, base_r;
  logic [SW-1:0]        step_r;
  logic [adxf_pkg::TRANSITION_LEN-1:0] vld_r;
  logic                 rd_vld_r;
  adxf_pkg::blend_t     b_r, g_r;
  logic signed [PW-1:0] p_r;
  logic signed [AW-1:0] acc_r;

  logic [SW-1:0]        eff_step, step_nxt;
  logic [HW-1:0]        pos, eff_base, rd_addr, hi_nxt;
  logic [HW:0]          addr_sum, addr_wrap;
  adxf_pkg::blend_t     blend_new;
  logic [ROW_W-1:0]     wr_row, rd_row;
  adxf_pkg::sample_t    hist_s, mul_a, rnd_out;
  adxf_pkg::blend_t     mul_b;
  logic signed [PW-1:0] a_ext, b_ext, prod;
  logic signed [AW-1:0] rnd_in, rnd_sum, rnd_q;
  logic                 src_on, out_on;

  // Blend position and ring address of the replayed tail
  always_comb begin
    eff_step  = cmd.snap ? '0 : step_r;
    pos       = (eff_step >= STEP_LAST) ? POS_MAX : eff_step[HW-1:0];
    blend_new = adxf_pkg::BLEND_LUT[pos];
    eff_base  = cmd.snap ? hi_r : base_r;
    addr_sum  = {1'b0, eff_base} + {1'b0, pos};
    addr_wrap = addr_sum - LEN_EXT;
    rd_addr   = (addr_sum >= LEN_EXT) ? addr_wrap[HW-1:0] : addr_sum[HW-1:0];
    if (cmd.blend) begin
      step_nxt = (eff_step < STEP_FULL) ? eff_step + 1'b1 : STEP_FULL;
    end else if (cmd.snap) begin
      step_nxt = '0;
    end else begin
      step_nxt = step_r;
    end
    hi_nxt = (hi_r == POS_MAX) ? '0 : hi_r + 1'b1;
  end

  always_comb begin
    for (int c = 0; c < adxf_pkg::NCH; c++) begin
      wr_row[c*SB +: SB] = frame_r[c];
    end
  end

  adxf_ram #(
    .WIDTH (ROW_W),
    .DEPTH (adxf_pkg::TRANSITION_LEN)
  ) u_hist_ram (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (hi_r),
    .wdata (wr_row),
    .re    (cmd.blend),
    .raddr (rd_addr),
    .rdata (rd_row)
  );

  // Operand selection and the shared multiplier
  always_comb begin
    src_on = adxf_pkg::chan_cnt_t'(cmd.ch) < src_cnt_r;
    out_on = adxf_pkg::chan_cnt_t'(cmd.ch) < out_cnt_r;
    hist_s = rd_vld_r ? adxf_pkg::sample_t'(rd_row[cmd.ch*SB +: SB]) : '0;
    case (cmd.a_sel)
      adxf_pkg::A_ORIGIN: mul_a = origin_r[cmd.ch];
      adxf_pkg::A_INPUT:  mul_a = src_on ? smp_r[cmd.ch] : '0;
      adxf_pkg::A_HIST:   mul_a = hist_s;
      adxf_pkg::A_TEMP:   mul_a = t_r;
      default:            mul_a = '0;
    endcase
    mul_b = (cmd.b_sel == adxf_pkg::B_BLEND) ? b_r : g_r;
    a_ext = {{(PW - SB){mul_a[SB-1]}}, mul_a};
    b_ext = {{(PW - adxf_pkg::BLEND_W){1'b0}}, mul_b};
    prod  = a_ext * b_ext;
  end

  // Round half up at bit 16, then saturate to the sample range
  always_comb begin
    rnd_in  = (cmd.rnd_src == adxf_pkg::RND_PROD) ? {p_r[PW-1], p_r} : acc_r;
    rnd_sum = rnd_in + RND_HALF;
    rnd_q   = rnd_sum >>> adxf_pkg::FRAC_W;
    if (rnd_q > SAT_MAX) begin
      rnd_out = SAT_MAX[SB-1:0];
    end else if (rnd_q < SAT_MIN) begin
      rnd_out = SAT_MIN[SB-1:0];
    end else begin
      rnd_out = rnd_q[SB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_cnt_r <= adxf_pkg::CH_CNT_RESET;
      out_cnt_r <= adxf_pkg::CH_CNT_RESET;
      hi_r      <= '0;
      base_r    <= '0;
      step_r    <= STEP_FULL;
      vld_r     <= '0;
      for (int c = 0; c < adxf_pkg::NCH; c++) begin
        origin_r[c] <= '0;
        last_r[c]   <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          adxf_pkg::CFG_SOURCE_CH: src_cnt_r <= cfg_wdata;
          adxf_pkg::CFG_OUTPUT_CH: out_cnt_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.clear) begin
        hi_r   <= '0;
        base_r <= '0;
        step_r <= STEP_FULL;
        vld_r  <= '0;
        for (int c = 0; c < adxf_pkg::NCH; c++) begin
          origin_r[c] <= '0;
          last_r[c]   <= '0;
        end
      end else begin
        if (cmd.snap) begin
          base_r <= hi_r;
          for (int c = 0; c < adxf_pkg::NCH; c++) begin
            origin_r[c] <= last_r[c];
          end
        end
        if (cmd.snap || cmd.blend) begin
          step_r <= step_nxt;
        end
        if (cmd.commit) begin
          vld_r[hi_r] <= 1'b1;
          hi_r        <= hi_nxt;
          for (int c = 0; c < adxf_pkg::NCH; c++) begin
            last_r[c] <= frame_r[c];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      smp_r[0] <= in_left;
      smp_r[1] <= in_right;
    end
    if (cmd.blend) begin
      b_r      <= blend_new;
      g_r      <= adxf_pkg::BLEND_ONE - blend_new;
      rd_vld_r <= vld_r[rd_addr];
    end
    if (cmd.mul_en) begin
      p_r <= prod;
    end
    case (cmd.acc_op)
      adxf_pkg::ACC_LOAD: acc_r <= {p_r[PW-1], p_r};
      adxf_pkg::ACC_ADD:  acc_r <= acc_r + {p_r[PW-1], p_r};
      default:            acc_r <= acc_r;
    endcase
    if (cmd.store_t) begin
      t_r <= rnd_out;
    end
    if (cmd.clear) begin
      for (int c = 0; c < adxf_pkg::NCH; c++) begin
        frame_r[c] <= '0;
      end
    end else if (cmd.store_frame) begin
      frame_r[cmd.ch] <= out_on ? rnd_out : '0;
    end
    if (cmd.emit) begin
      out_left_r  <= frame_r[0];
      out_right_r <= frame_r[1];
    end
  end

  assign out_left  = out_left_r;
  assign out_right = out_right_r;

endmodule

@@ rtl/core/audio_dropout_crossfader.sv @@
// Top level of the stereo dropout crossfader: sequencer, datapath and port binding.
// Frame: prepare, then per channel two multiplies, a sum and a rounding, then commit and emit.
// Missing frame adds a gain rescale of each rounded result; mute clears and emits; restart and transition emit nothing.
// One shared 24x17 multiplier walks each channel in turn; a new command is taken only back in idle, after any emit.
// Reset is synchronous, active low; history valid bits clear at once, so no clearing pass.
module audio_dropout_crossfader (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  adxf_pkg::cfg_idx_t  cfg_index,
  input  adxf_pkg::chan_cnt_t cfg_wdata,
  adxf_in_if.sink             in_chan,
  adxf_out_if.source          out_chan
);

  // Command bundle from the sequencer to the datapath; the sequencer owns
  // both handshakes, the datapath owns all sample and history state.
  adxf_pkg::dp_cmd_t cmd;

  adxf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_opcode (in_chan.opcode),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd)
  );

  // The replayed tail is read straight from the live history ring at the
  // base captured by the last snapshot: entries past that base are only
  // overwritten after they have been replayed, so no copy is taken.
  adxf_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .in_left   (in_chan.sample_left),
    .in_right  (in_chan.sample_right),
    .out_left  (out_chan.out_left),
    .out_right (out_chan.out_right)
  );

  // An unused opcode is dropped on transfer and leaves the block ready
  a_unused_op_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready && (in_chan.opcode > adxf_pkg::OP_TRANSITION)
    |=> in_chan.ready)
    else $error("block busy after an unused opcode");

  // While taking input, the datapath must not multiply, blend, commit, clear or emit
  a_ready_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.ready |-> !(cmd.mul_en || cmd.commit || cmd.emit || cmd.clear || cmd.blend))
    else $error("datapath active while input ready");

  // Capture, multiply, commit, clear and emit belong to distinct steps
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.capture, cmd.mul_en, cmd.commit, cmd.clear, cmd.emit}))
    else $error("conflicting datapath commands");

  // A received frame keeps the block busy on the following cycle
  a_frame_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready && (in_chan.opcode == adxf_pkg::OP_FRAME)
    |=> !in_chan.ready)
    else $error("frame transfer did not start processing");

endmodule
